@@ hw/rtl/aefc_pkg.sv @@
`default_nettype none

package aefc_pkg;

    localparam logic [23:0] HEADER_MARK     = 24'hFCBBCF;
    localparam logic [23:0] TRAILER_MARK    = 24'hABCCBA;
    localparam logic [15:0] MAX_WORDS_RESET = 16'd120;
    localparam logic [15:0] WORD_COUNT_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_TRAILER = 3'd2,
        KIND_ERROR   = 3'd3,
        KIND_SKIP    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SIZE     = 3'd1,
        ST_NOHEAD   = 3'd2,
        ST_NOTRAIL  = 3'd3,
        ST_MISMATCH = 3'd4
    } status_t;

    typedef struct packed {
        logic [31:0] word;
        logic        last_word;
    } item_t;

    typedef struct packed {
        kind_t       word_kind;
        logic [7:0]  event_number;
        logic [3:0]  channel;
        logic [11:0] sample;
        status_t     status;
        logic        buffer_done;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/aefc_if.sv @@
`default_nettype none

interface aefc_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        last_word;

    modport source (output valid, output word, output last_word, input ready);
    modport sink (input valid, input word, input last_word, output ready);
endinterface

interface aefc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  word_kind;
    logic [7:0]  event_number;
    logic [3:0]  channel;
    logic [11:0] sample;
    logic [2:0]  status;
    logic        buffer_done;

    modport source (
        output valid, output word_kind, output event_number, output channel,
        output sample, output status, output buffer_done, input ready
    );
    modport sink (
        input valid, input word_kind, input event_number, input channel,
        input sample, input status, input buffer_done, output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/adc_event_frame_checker.sv @@
// Checks readout buffers made of events: a header word carrying the event
// number, up to MAX_DATA_PER_EVENT data words, and a trailer whose low byte
// repeats the event number. The words channel takes one 32-bit word per
// transfer, with last_word set on the final word of a buffer. The results
// channel gives one result per word: its kind, the current event number,
// channel and sample for data words, and the buffer status.
// The first error in a buffer is reported on its word; later words of the
// same buffer come out as skipped. All buffer state clears after a last word.
// A word passes through an input register and then a result register, and
// one word per cycle is sustained while the receiver takes every result.
// The frame state is updated as a word moves into the result register.
// When the receiver stalls, the result register holds, and once the input
// register holds a word, ready falls in the same cycle.
// Reset empties both registers, clears the frame state and sets max_words
// to 120. max_words is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while the block is idle, which the block does not enforce.
`default_nettype none

module adc_event_frame_checker
    import aefc_pkg::*;
#(
    parameter int MAX_DATA_PER_EVENT = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    aefc_word_if.sink        words,
    aefc_result_if.source    results
);

    item_t   item;
    logic    item_valid;
    logic    space;
    logic    take;
    result_t result;

    assign take = item_valid && space;

    aefc_input_reg u_input_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .words      (words),
        .take       (take),
        .item       (item),
        .item_valid (item_valid)
    );

    aefc_frame_logic #(
        .MAX_DATA_PER_EVENT (MAX_DATA_PER_EVENT)
    ) u_frame_logic (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .advance     (take),
        .result      (result)
    );

    aefc_result_reg u_result_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .result  (result),
        .load    (take),
        .space   (space),
        .results (results)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> results.valid)
        else $error("A word left the input register without a result appearing.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.word_kind == KIND_SKIP) |-> results.status != ST_OK)
        else $error("A skipped word was reported without a stored error.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.word_kind == KIND_ERROR) |->
        (results.channel == 4'd0 && results.sample == 12'd0 && results.status != ST_OK))
        else $error("An error result carries data fields or an ok status.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status == ST_OK) |->
        (results.word_kind == KIND_HEADER || results.word_kind == KIND_DATA ||
         results.word_kind == KIND_TRAILER))
        else $error("An ok status was given with an error or skipped kind.");

endmodule

`default_nettype wire

@@ hw/rtl/aefc_input_reg.sv @@
`default_nettype none

module aefc_input_reg
    import aefc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    aefc_word_if.sink  words,
    input  wire logic  take,
    output item_t      item,
    output logic       item_valid
);

    item_t item_reg;
    logic  valid_reg;
    logic  valid_next;
    logic  load;

    assign words.ready = !valid_reg || take;
    assign load        = words.valid && words.ready;
    assign valid_next  = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.word      <= words.word;
            item_reg.last_word <= words.last_word;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/aefc_frame_logic.sv @@
`default_nettype none

module aefc_frame_logic
    import aefc_pkg::*;
#(
    parameter int MAX_DATA_PER_EVENT = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire item_t       item,
    input  wire logic        advance,
    output result_t          result
);

    localparam int DC_W = $clog2(MAX_DATA_PER_EVENT + 1);
    localparam logic [DC_W-1:0] DATA_LIMIT = DC_W'(MAX_DATA_PER_EVENT);

    logic [15:0]     max_words_reg;
    logic            in_body_reg;
    logic            in_body_next;
    logic [7:0]      event_reg;
    logic [7:0]      event_next;
    logic [DC_W-1:0] data_count_reg;
    logic [DC_W-1:0] data_count_next;
    logic [15:0]     word_count_reg;
    logic [15:0]     word_count_next;
    status_t         error_reg;
    status_t         error_next;

    always_comb
    begin
        kind_t       kind;
        status_t     err;
        logic [3:0]  chan;
        logic [11:0] samp;
        logic [23:0] mark;

        mark            = item.word[31:8];
        kind            = KIND_SKIP;
        err             = ST_OK;
        chan            = '0;
        samp            = '0;
        in_body_next    = in_body_reg;
        event_next      = event_reg;
        data_count_next = data_count_reg;
        error_next      = error_reg;

        priority if (error_reg != ST_OK)
        begin
            kind = KIND_SKIP;
        end
        else if (word_count_reg >= max_words_reg)
        begin
            err = ST_SIZE;
        end
        else if (!in_body_reg)
        begin
            if (mark == HEADER_MARK)
            begin
                kind            = KIND_HEADER;
                event_next      = item.word[7:0];
                data_count_next = '0;
                in_body_next    = 1'b1;
            end
            else
            begin
                err = ST_NOHEAD;
            end
        end
        else if (mark == TRAILER_MARK)
        begin
            if (item.word[7:0] == event_reg)
            begin
                kind         = KIND_TRAILER;
                in_body_next = 1'b0;
            end
            else
            begin
                err = ST_MISMATCH;
            end
        end
        else if (data_count_reg < DATA_LIMIT)
        begin
            kind            = KIND_DATA;
            chan            = item.word[15:12];
            samp            = item.word[11:0];
            data_count_next = data_count_reg + 1'b1;
        end
        else
        begin
            err = ST_NOTRAIL;
        end

        if (err == ST_OK && error_reg == ST_OK && item.last_word && in_body_next)
        begin
            err = ST_NOTRAIL;
        end

        if (err != ST_OK)
        begin
            kind       = KIND_ERROR;
            chan       = '0;
            samp       = '0;
            error_next = err;
        end

        word_count_next = (word_count_reg < WORD_COUNT_MAX) ?
                          word_count_reg + 16'd1 : word_count_reg;

        result.word_kind    = kind;
        result.event_number = event_next;
        result.channel      = chan;
        result.sample       = samp;
        result.status       = error_next;
        result.buffer_done  = item.last_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_words_reg <= MAX_WORDS_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_words_reg <= cfg_wr_data;
        end
    end

    // Every state field returns to its reset value after the last word of a buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg    <= 1'b0;
            event_reg      <= '0;
            data_count_reg <= '0;
            word_count_reg <= '0;
            error_reg      <= ST_OK;
        end
        else if (advance)
        begin
            if (item.last_word)
            begin
                in_body_reg    <= 1'b0;
                event_reg      <= '0;
                data_count_reg <= '0;
                word_count_reg <= '0;
                error_reg      <= ST_OK;
            end
            else
            begin
                in_body_reg    <= in_body_next;
                event_reg      <= event_next;
                data_count_reg <= data_count_next;
                word_count_reg <= word_count_next;
                error_reg      <= error_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/aefc_result_reg.sv @@
`default_nettype none

module aefc_result_reg
    import aefc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire result_t  result,
    input  wire logic     load,
    output logic          space,
    aefc_result_if.source results
);

    result_t result_reg;
    logic    valid_reg;
    logic    valid_next;

    assign space      = !valid_reg || results.ready;
    assign valid_next = load ? 1'b1 : (results.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign results.valid        = valid_reg;
    assign results.word_kind    = result_reg.word_kind;
    assign results.event_number = result_reg.event_number;
    assign results.channel      = result_reg.channel;
    assign results.sample       = result_reg.sample;
    assign results.status       = result_reg.status;
    assign results.buffer_done  = result_reg.buffer_done;

endmodule

`default_nettype wire

@@ tb/aefc_result_checker.sv @@
`timescale 1ns / 1ps

module aefc_result_checker
    import aefc_pkg::*;
#(
    parameter int MAX_DATA_PER_EVENT = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    aefc_word_if             words,
    aefc_result_if           results,
    output int               pending,
    output int               mismatch_count
);

    logic [15:0] max_words = MAX_WORDS_RESET;
    logic        in_body = 1'b0;
    logic [7:0]  cur_event = '0;
    logic [3:0]  data_count = '0;
    logic [15:0] word_count = '0;
    status_t     frame_err = ST_OK;

    result_t     expected_results[$];
    int          fail_count = 0;

    function automatic void clear_frame();
        in_body    = 1'b0;
        cur_event  = '0;
        data_count = '0;
        word_count = '0;
        frame_err  = ST_OK;
    endfunction

    function automatic result_t predict_result(input logic [31:0] w, input logic is_last);
        result_t r;
        status_t found;
        kind_t   kind;
        found     = ST_OK;
        kind      = KIND_SKIP;
        r.channel = '0;
        r.sample  = '0;
        if (frame_err != ST_OK) begin
            kind = KIND_SKIP;
        end
        else if (word_count >= max_words) begin
            found = ST_SIZE;
        end
        else if (!in_body) begin
            if (w[31:8] == HEADER_MARK) begin
                kind       = KIND_HEADER;
                cur_event  = w[7:0];
                data_count = '0;
                in_body    = 1'b1;
            end
            else begin
                found = ST_NOHEAD;
            end
        end
        else if (w[31:8] == TRAILER_MARK) begin
            if (w[7:0] == cur_event) begin
                kind    = KIND_TRAILER;
                in_body = 1'b0;
            end
            else begin
                found = ST_MISMATCH;
            end
        end
        else if (data_count < MAX_DATA_PER_EVENT) begin
            kind       = KIND_DATA;
            r.channel  = w[15:12];
            r.sample   = w[11:0];
            data_count = data_count + 4'd1;
        end
        else begin
            found = ST_NOTRAIL;
        end

        if (found == ST_OK && frame_err == ST_OK && is_last && in_body) begin
            found = ST_NOTRAIL;
        end

        if (found != ST_OK) begin
            kind      = KIND_ERROR;
            r.channel = '0;
            r.sample  = '0;
            frame_err = found;
        end

        if (word_count != WORD_COUNT_MAX) begin
            word_count = word_count + 16'd1;
        end

        r.word_kind    = kind;
        r.event_number = cur_event;
        r.status       = frame_err;
        r.buffer_done  = is_last;

        if (is_last) begin
            clear_frame();
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n) begin
            max_words = MAX_WORDS_RESET;
            clear_frame();
            expected_results.delete();
            fail_count = 0;
            pending        <= 0;
            mismatch_count <= 0;
        end
        else begin
            if (cfg_wr_en) begin
                max_words = cfg_wr_data;
            end

            if (words.valid && words.ready) begin
                expected_results.push_back(predict_result(words.word, words.last_word));
            end

            if (results.valid && results.ready) begin
                got.word_kind    = kind_t'(results.word_kind);
                got.event_number = results.event_number;
                got.channel      = results.channel;
                got.sample       = results.sample;
                got.status       = status_t'(results.status);
                got.buffer_done  = results.buffer_done;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t unexpected result: kind %0d event %0d ch %0d sample %0d status %0d done %0d",
                                 $realtime, got.word_kind, got.event_number, got.channel,
                                 got.sample, got.status, got.buffer_done);
                    end
                end
                else begin
                    want = expected_results.pop_front();
                    if (got.word_kind !== want.word_kind
                        || got.event_number !== want.event_number
                        || got.channel !== want.channel
                        || got.sample !== want.sample
                        || got.status !== want.status
                        || got.buffer_done !== want.buffer_done) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t mismatch: expected kind %0d event %0d ch %0d sample %0d status %0d done %0d",
                                     $realtime, want.word_kind, want.event_number, want.channel,
                                     want.sample, want.status, want.buffer_done);
                            $display("%0t            got kind %0d event %0d ch %0d sample %0d status %0d done %0d",
                                     $realtime, got.word_kind, got.event_number, got.channel,
                                     got.sample, got.status, got.buffer_done);
                        end
                    end
                end
            end

            pending        <= expected_results.size();
            mismatch_count <= fail_count;
        end
    end

endmodule

@@ tb/adc_event_frame_checker_tb.sv @@
`timescale 1ns / 1ps

module adc_event_frame_checker_tb;

    import aefc_pkg::*;

    localparam int MAX_DATA    = 8;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum int {
        FAULT_NONE,
        FAULT_NO_HEADER,
        FAULT_BAD_TRAILER,
        FAULT_NO_TRAILER,
        FAULT_EXTRA_DATA,
        FAULT_TRUNCATE,
        FAULT_NOISE
    } fault_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int pending;
    int mismatch_count;
    int cycle_count = 0;

    logic [31:0] frame_words[$];

    aefc_word_if   word_ch();
    aefc_result_if result_ch();

    adc_event_frame_checker #(
        .MAX_DATA_PER_EVENT(MAX_DATA)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .words      (word_ch),
        .results    (result_ch)
    );

    aefc_result_checker #(
        .MAX_DATA_PER_EVENT(MAX_DATA)
    ) frame_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .words         (word_ch),
        .results       (result_ch),
        .pending       (pending),
        .mismatch_count(mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] header_word(input logic [7:0] evt);
        return {HEADER_MARK, evt};
    endfunction

    function automatic logic [31:0] trailer_word(input logic [7:0] evt);
        return {TRAILER_MARK, evt};
    endfunction

    task automatic send_word(input logic [31:0] w, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            word_ch.valid <= 1'b0;
            @(posedge clk);
        end
        word_ch.valid     <= 1'b1;
        word_ch.word      <= w;
        word_ch.last_word <= is_last;
        @(posedge clk);
        while (!word_ch.ready) begin
            @(posedge clk);
        end
    endtask

    task automatic send_buffer();
        for (int i = 0; i < frame_words.size(); i++) begin
            send_word(frame_words[i], i == frame_words.size() - 1);
        end
    endtask

    task automatic drain();
        word_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_max_words(input logic [15:0] value);
        drain();
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic build_random_buffer();
        int     n_events;
        int     n_data;
        int     fault_event;
        int     cut;
        fault_t fault;
        logic [7:0] evt;
        frame_words.delete();
        n_events    = $urandom_range(1, 4);
        fault_event = $urandom_range(0, n_events - 1);
        fault       = FAULT_NONE;
        if ($urandom_range(0, 99) < 30) begin
            fault = fault_t'($urandom_range(FAULT_NO_HEADER, FAULT_NOISE));
        end
        for (int e = 0; e < n_events; e++) begin
            evt    = 8'($urandom_range(0, 255));
            n_data = $urandom_range(0, MAX_DATA);
            if (fault == FAULT_EXTRA_DATA && e == fault_event) begin
                n_data = MAX_DATA + $urandom_range(1, 3);
            end
            if (!(fault == FAULT_NO_HEADER && e == fault_event)) begin
                frame_words.push_back(header_word(evt));
            end
            for (int d = 0; d < n_data; d++) begin
                frame_words.push_back($urandom());
            end
            if (fault == FAULT_BAD_TRAILER && e == fault_event) begin
                frame_words.push_back(trailer_word(evt ^ 8'($urandom_range(1, 255))));
            end
            else if (!(fault == FAULT_NO_TRAILER && e == fault_event)) begin
                frame_words.push_back(trailer_word(evt));
            end
        end
        if (fault == FAULT_TRUNCATE && frame_words.size() > 1) begin
            cut = $urandom_range(1, frame_words.size() - 1);
            repeat (cut) frame_words.pop_back();
        end
        if (fault == FAULT_NOISE) begin
            frame_words.insert($urandom_range(0, frame_words.size()), $urandom());
        end
        if (frame_words.size() == 0) begin
            frame_words.push_back($urandom());
        end
    endtask

    task automatic run_random_words(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            build_random_buffer();
            send_buffer();
            sent += frame_words.size();
            if ($urandom_range(0, 39) == 0) begin
                drain();
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        word_ch.valid     = 1'b0;
        word_ch.word      = '0;
        word_ch.last_word = 1'b0;

        send_idle_pct = 32;
        recv_idle_pct = 70;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        frame_words = '{header_word(8'hFF), 32'h0000_FFFF, 32'h0000_0000, trailer_word(8'hFF)};
        send_buffer();
        frame_words = '{32'hFFFF_FFFF, header_word(8'h01)};
        send_buffer();
        frame_words = '{header_word(8'h12), trailer_word(8'h13), header_word(8'h12)};
        send_buffer();
        frame_words.delete();
        frame_words.push_back(header_word(8'h00));
        for (int d = 0; d <= MAX_DATA; d++) begin
            frame_words.push_back({16'hFFFF, 4'(d), 12'hA5A});
        end
        frame_words.push_back(trailer_word(8'h00));
        send_buffer();
        frame_words = '{header_word(8'h55)};
        send_buffer();
        frame_words = '{header_word(8'h56), 32'h1234_5ABC};
        send_buffer();

        write_max_words(16'd2);
        frame_words = '{header_word(8'h00), trailer_word(8'h00), header_word(8'h01)};
        send_buffer();

        write_max_words(MAX_WORDS_RESET);
        run_random_words(350);

        write_max_words(16'd1);
        run_random_words(150);

        send_idle_pct = 70;
        recv_idle_pct = 32;
        write_max_words(16'hFFFF);
        run_random_words(350);

        write_max_words(16'($urandom_range(4, 40)));
        run_random_words(350);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_max_words(16'($urandom_range(1, 65535)));
        run_random_words(350);

        write_max_words(16'd9);
        run_random_words(350);

        drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end
        else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
